// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the frame parser RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication
`define CFRP_ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
// Next-cycle implication
`define CFRP_ASSERT_NXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define CFRP_ASSERT_IMP(label, clk, rst, a, b)
`define CFRP_ASSERT_NXT(label, clk, rst, a, b)
`endif
`endif

// ===== rtl/cfrp_pkg.sv =====
// Types, codes and helper functions of the framed response parser
package cfrp_pkg;

  typedef enum logic [1:0] {
    OP_BYTE  = 2'd0,
    OP_TICK  = 2'd1,
    OP_START = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_NONE    = 2'd0,
    ST_OK      = 2'd1,
    ST_NOK     = 2'd2,
    ST_TIMEOUT = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_DST  = 3'd1,
    PH_SRC  = 3'd2,
    PH_CRC  = 3'd3,
    PH_TAIL = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    TM_NONE = 3'd0,
    TM_O    = 3'd1,
    TM_OK   = 3'd2,
    TM_N    = 3'd3,
    TM_NO   = 3'd4,
    TM_NOK  = 3'd5,
    TM_BAD  = 3'd7
  } tail_t;

  localparam logic [1:0] CFG_OWN_ADDRESS  = 2'd0;
  localparam logic [1:0] CFG_PEER_ADDRESS = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT      = 2'd2;

  localparam logic [15:0] TIMEOUT_RESET = 16'd50;
  localparam logic [7:0]  CRC_POLY      = 8'h8C;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_K     = 8'h4B;
  localparam logic [7:0] CH_N     = 8'h4E;

  typedef struct packed {
    logic [7:0]  own_address;
    logic [7:0]  peer_address;
    logic [15:0] timeout_ticks;
  } cfg_t;

  // Reflected CRC-8, one byte, LSB first
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    logic [7:0] d;
    c = crc;
    d = b;
    for (int i = 0; i < 8; i++) begin
      if (c[0] ^ d[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
      d = d >> 1;
    end
    return c;
  endfunction

  // Hex digit decode: bit 4 marks a valid digit, bits 3:0 hold its value
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c inside {[8'h30:8'h39]}) begin
      v = c - 8'h30;
      return {1'b1, v[3:0]};
    end else if (c inside {[8'h41:8'h46]}) begin
      v = c - 8'h37;
      return {1'b1, v[3:0]};
    end else if (c inside {[8'h61:8'h66]}) begin
      v = c - 8'h57;
      return {1'b1, v[3:0]};
    end
    return 5'd0;
  endfunction

endpackage

// ===== rtl/crc8_framed_response_parser_unit.sv =====
// Top level of the framed response parser: input word register and result register
//
// Usage: each input word carries op (0 received byte, 1 time tick, 2 start wait)
// and byte_value. A word is taken at a rising edge with item_valid high and
// item_stall low. Every accepted word gives exactly one result word on the
// result channel (status: 0 nothing yet, 1 ok, 2 not ok, 3 timeout), in order.
// Pipeline: an accepted word moves from the input register into the result register,
// where its status shows; two register stages in total.
// Throughput: one word per cycle while item_stall is low; the parser state updates as
// each word advances, the CRC-8 byte update unrolled between input and result registers.
// When result_stall holds the result register full, the input register still
// takes one more word; item_stall rises only when both registers are full.
// Reset (rst, synchronous) empties both registers, stops the wait and loads the
// default configuration: addresses 0, timeout 50 ticks.
// Configuration: cfg_we with cfg_index 0 own address, 1 peer address,
// 2 timeout ticks; write only while no word is in flight.
`include "assert_macros.svh"
module crc8_framed_response_parser_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [1:0]  op,
  input  logic [7:0]  byte_value,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [1:0]  status,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import cfrp_pkg::*;

  cfg_t       cfg;
  logic       s1_valid;
  logic [1:0] s1_op;
  logic [7:0] s1_byte;
  logic       s1_advance;
  status_t    step_status;

  assign s1_advance = s1_valid && (!result_valid || !result_stall);
  assign item_stall = s1_valid && !s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!item_stall) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      s1_op   <= op;
      s1_byte <= byte_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      status <= step_status;
    end
  end

  cfrp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  cfrp_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (s1_advance),
    .op          (s1_op),
    .byte_value  (s1_byte),
    .cfg         (cfg),
    .step_status (step_status)
  );

  `CFRP_ASSERT_NXT(a_s1_holds, clk, rst, s1_valid && !s1_advance,
                   s1_valid && $stable(s1_op) && $stable(s1_byte))
  `CFRP_ASSERT_NXT(a_advance_fills_result, clk, rst, s1_advance, result_valid)

endmodule

// ===== rtl/cfrp_cfg.sv =====
// Configuration registers: addresses and tick timeout
module cfrp_cfg (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [15:0]    cfg_data,
  output cfrp_pkg::cfg_t cfg
);
  import cfrp_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.own_address   <= 8'd0;
      cfg.peer_address  <= 8'd0;
      cfg.timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OWN_ADDRESS:  cfg.own_address   <= cfg_data[7:0];
        CFG_PEER_ADDRESS: cfg.peer_address  <= cfg_data[7:0];
        CFG_TIMEOUT:      cfg.timeout_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/cfrp_core.sv =====
// Frame parser state, CRC check and tick timeout
`include "assert_macros.svh"
module cfrp_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [1:0]        op,
  input  logic [7:0]        byte_value,
  input  cfrp_pkg::cfg_t    cfg,
  output cfrp_pkg::status_t step_status
);
  import cfrp_pkg::*;

  logic        waiting, waiting_next;
  phase_t      phase, phase_next;
  logic [7:0]  field_value, field_value_next;
  logic [1:0]  digit_count, digit_count_next;
  logic [7:0]  received_crc, received_crc_next;
  logic [7:0]  running_crc, running_crc_next;
  tail_t       tail, tail_next;
  logic [15:0] ticks_left, ticks_left_next;

  logic        do_clear;
  logic [4:0]  hex;
  logic        field_push, field_done, field_drop;
  logic [7:0]  crc_base, crc_out;
  logic [7:0]  want;

  assign hex        = hex_decode(byte_value);
  assign field_push = hex[4] && (digit_count < 2'd2);
  assign field_done = !field_push && (byte_value == CH_SPACE) && (digit_count == 2'd2);
  assign field_drop = !field_push && !field_done;
  assign crc_base   = (byte_value == CH_AT) ? 8'd0 : running_crc;
  assign crc_out    = crc8_update(crc_base, byte_value);
  assign want       = (phase == PH_DST) ? cfg.own_address : cfg.peer_address;

  always_comb begin
    waiting_next      = waiting;
    phase_next        = phase;
    field_value_next  = field_value;
    digit_count_next  = digit_count;
    received_crc_next = received_crc;
    running_crc_next  = running_crc;
    tail_next         = tail;
    ticks_left_next   = ticks_left;
    step_status       = ST_NONE;
    do_clear          = 1'b0;

    case (op_t'(op))
      OP_START: begin
        do_clear        = 1'b1;
        waiting_next    = 1'b1;
        ticks_left_next = cfg.timeout_ticks;
      end
      OP_TICK: begin
        if (waiting) begin
          if (ticks_left <= 16'd1) begin
            ticks_left_next = 16'd0;
            waiting_next    = 1'b0;
            do_clear        = 1'b1;
            step_status     = ST_TIMEOUT;
          end else begin
            ticks_left_next = ticks_left - 16'd1;
          end
        end
      end
      OP_BYTE: begin
        if (waiting && byte_value != CH_NUL) begin
          if (byte_value == CH_AT) begin
            // restart the frame at this marker
            phase_next        = PH_DST;
            field_value_next  = 8'd0;
            digit_count_next  = 2'd0;
            received_crc_next = 8'd0;
            running_crc_next  = crc_out;
            tail_next         = TM_NONE;
          end else begin
            case (phase)
              PH_DST, PH_SRC: begin
                running_crc_next = crc_out;
                if (field_push) begin
                  field_value_next = {field_value[3:0], hex[3:0]};
                  digit_count_next = digit_count + 2'd1;
                end else if (field_done) begin
                  if (field_value != want) begin
                    do_clear = 1'b1;
                  end else begin
                    phase_next       = (phase == PH_DST) ? PH_SRC : PH_CRC;
                    field_value_next = 8'd0;
                    digit_count_next = 2'd0;
                  end
                end else begin
                  do_clear = 1'b1;
                end
              end
              PH_CRC: begin
                if (field_push) begin
                  field_value_next = {field_value[3:0], hex[3:0]};
                  digit_count_next = digit_count + 2'd1;
                end else if (field_done) begin
                  running_crc_next  = crc_out;
                  received_crc_next = field_value;
                  field_value_next  = 8'd0;
                  digit_count_next  = 2'd0;
                  tail_next         = TM_NONE;
                  phase_next        = PH_TAIL;
                end else begin
                  do_clear = 1'b1;
                end
              end
              PH_TAIL: begin
                if (byte_value == CH_NL) begin
                  if (tail == TM_OK) begin
                    step_status = (running_crc == received_crc) ? ST_OK : ST_NOK;
                  end else if (tail == TM_NOK) begin
                    step_status = ST_NOK;
                  end
                  do_clear = 1'b1;
                  if (tail == TM_OK || tail == TM_NOK) begin
                    waiting_next = 1'b0;
                  end
                end else begin
                  running_crc_next = crc_out;
                  if (tail == TM_NONE && byte_value == CH_O) begin
                    tail_next = TM_O;
                  end else if (tail == TM_NONE && byte_value == CH_N) begin
                    tail_next = TM_N;
                  end else if (tail == TM_O && byte_value == CH_K) begin
                    tail_next = TM_OK;
                  end else if (tail == TM_N && byte_value == CH_O) begin
                    tail_next = TM_NO;
                  end else if (tail == TM_NO && byte_value == CH_K) begin
                    tail_next = TM_NOK;
                  end else begin
                    tail_next = TM_BAD;
                  end
                end
              end
              default: do_clear = 1'b1;
            endcase
          end
        end
      end
      default: ;
    endcase

    // drop the frame: overrides any field update above
    if (do_clear) begin
      phase_next        = PH_HUNT;
      field_value_next  = 8'd0;
      digit_count_next  = 2'd0;
      received_crc_next = 8'd0;
      running_crc_next  = 8'd0;
      tail_next         = TM_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      waiting      <= 1'b0;
      phase        <= PH_HUNT;
      field_value  <= 8'd0;
      digit_count  <= 2'd0;
      received_crc <= 8'd0;
      running_crc  <= 8'd0;
      tail         <= TM_NONE;
      ticks_left   <= 16'd0;
    end else if (step) begin
      waiting      <= waiting_next;
      phase        <= phase_next;
      field_value  <= field_value_next;
      digit_count  <= digit_count_next;
      received_crc <= received_crc_next;
      running_crc  <= running_crc_next;
      tail         <= tail_next;
      ticks_left   <= ticks_left_next;
    end
  end

  `CFRP_ASSERT_IMP(a_idle_hunts, clk, rst, !waiting, phase == PH_HUNT)
  `CFRP_ASSERT_IMP(a_tail_only_in_tail, clk, rst, phase != PH_TAIL, tail == TM_NONE)
  `CFRP_ASSERT_NXT(a_start_arms, clk, rst, step && op == OP_START,
                   waiting && ticks_left == $past(cfg.timeout_ticks))

endmodule
